FILE: sv/psda_pkg.sv
`default_nettype none
package psda_pkg;

  localparam int unsigned CLIENTS_DEF = 10;

  localparam int unsigned IP_W    = 32;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned DATA_W  = 32;

  typedef enum logic {
    OP_CLIENT  = 1'b0,
    OP_REPLICA = 1'b1
  } op_t;

  // lookup and update request into the source table
  typedef struct packed {
    logic                     en;
    logic [IP_W-1:0]          ip;
    logic [PORT_W-1:0]        port;
    logic signed [DATA_W-1:0] seq;
  } tbl_req_t;

  typedef struct packed {
    logic dup;
    logic untracked;
  } tbl_res_t;

  // accumulator command
  typedef struct packed {
    logic                     add;
    logic                     load;
    logic signed [DATA_W-1:0] value;
    logic [DATA_W-1:0]        load_count;
    logic signed [DATA_W-1:0] load_sum;
  } acc_cmd_t;

endpackage
`default_nettype wire

FILE: sv/psda_if.sv
`default_nettype none
interface psda_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   operation;
  logic [psda_pkg::IP_W-1:0]              src_ip;
  logic [psda_pkg::PORT_W-1:0]            src_port;
  logic signed [psda_pkg::DATA_W-1:0]     seq_num;
  logic signed [psda_pkg::DATA_W-1:0]     value;
  logic [psda_pkg::DATA_W-1:0]            replica_count;
  logic signed [psda_pkg::DATA_W-1:0]     replica_sum;

  modport source (
    output valid, operation, src_ip, src_port, seq_num, value, replica_count, replica_sum,
    input  ready
  );
  modport sink (
    input  valid, operation, src_ip, src_port, seq_num, value, replica_count, replica_sum,
    output ready
  );
endinterface

interface psda_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [psda_pkg::DATA_W-1:0] ack_total;
  logic [psda_pkg::DATA_W-1:0]        ack_count;
  logic                               is_duplicate;
  logic                               not_tracked;

  modport source (
    output valid, ack_total, ack_count, is_duplicate, not_tracked,
    input  ready
  );
  modport sink (
    input  valid, ack_total, ack_count, is_duplicate, not_tracked,
    output ready
  );
endinterface
`default_nettype wire

FILE: sv/psda_table.sv
`default_nettype none
module psda_table #(
  parameter int unsigned CLIENTS = psda_pkg::CLIENTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire psda_pkg::tbl_req_t req,
  output psda_pkg::tbl_res_t      res
);

  localparam int unsigned IDX_W = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;

  logic [CLIENTS-1:0]                     vld_r;
  logic [psda_pkg::IP_W-1:0]              ip_r   [CLIENTS];
  logic [psda_pkg::PORT_W-1:0]            port_r [CLIENTS];
  logic signed [psda_pkg::DATA_W-1:0]     seq_r  [CLIENTS];

  logic             hit_any;
  logic             free_any;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] free_idx;
  logic             dup;
  logic             upd_seq;
  logic             alloc;

  // lowest matching entry and lowest free entry
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < CLIENTS; i++) begin
      if (!hit_any && vld_r[i] && ip_r[i] == req.ip && port_r[i] == req.port) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!free_any && !vld_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign dup     = hit_any && ($signed(req.seq) <= $signed(seq_r[hit_idx]));
  assign upd_seq = req.en && hit_any && !dup;
  assign alloc   = req.en && !hit_any && free_any;

  assign res.dup       = dup;
  assign res.untracked = !hit_any && !free_any;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (alloc) begin
      vld_r[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_seq) begin
      seq_r[hit_idx] <= req.seq;
    end else if (alloc) begin
      ip_r[free_idx]   <= req.ip;
      port_r[free_idx] <= req.port;
      seq_r[free_idx]  <= req.seq;
    end
  end

endmodule
`default_nettype wire

FILE: sv/psda_acc.sv
`default_nettype none
module psda_acc (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire psda_pkg::acc_cmd_t                 cmd,
  output logic signed [psda_pkg::DATA_W-1:0]      total_nxt,
  output logic [psda_pkg::DATA_W-1:0]             count_nxt
);

  logic signed [psda_pkg::DATA_W-1:0] total_r;
  logic [psda_pkg::DATA_W-1:0]        count_r;

  always_comb begin
    total_nxt = total_r;
    count_nxt = count_r;
    if (cmd.load) begin
      total_nxt = cmd.load_sum;
      count_nxt = cmd.load_count;
    end else if (cmd.add) begin
      total_nxt = total_r + cmd.value;
      count_nxt = count_r + psda_pkg::DATA_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      count_r <= '0;
    end else begin
      total_r <= total_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/per_source_request_dedup_accumulator.sv
// an accepted request goes through the input register, then the result register
// throughput: one request per cycle unless a held result stalls; the source table match,
// the sequence compare and the 32-bit total add all settle combinationally between input
// and result register; replica overwrites take the same path and give no result
// reset (synchronous, active low) clears the table valid bits, total, count and both stages
`default_nettype none
module per_source_request_dedup_accumulator #(
  parameter int unsigned CLIENTS = psda_pkg::CLIENTS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  psda_in_if.sink     in_req,
  psda_out_if.source  out_rsp
);

  logic                               s1_valid_r;
  psda_pkg::op_t                      s1_op_r;
  logic [psda_pkg::IP_W-1:0]          s1_ip_r;
  logic [psda_pkg::PORT_W-1:0]        s1_port_r;
  logic signed [psda_pkg::DATA_W-1:0] s1_seq_r;
  logic signed [psda_pkg::DATA_W-1:0] s1_val_r;
  logic [psda_pkg::DATA_W-1:0]        s1_rcount_r;
  logic signed [psda_pkg::DATA_W-1:0] s1_rsum_r;

  logic                               out_valid_r;
  logic signed [psda_pkg::DATA_W-1:0] out_total_r;
  logic [psda_pkg::DATA_W-1:0]        out_count_r;
  logic                               out_dup_r;
  logic                               out_untr_r;

  logic                               s1_go;
  logic                               s1_client;
  logic                               in_fire;
  psda_pkg::tbl_req_t                 tbl_req;
  psda_pkg::tbl_res_t                 tbl_res;
  psda_pkg::acc_cmd_t                 acc_cmd;
  logic signed [psda_pkg::DATA_W-1:0] total_nxt;
  logic [psda_pkg::DATA_W-1:0]        count_nxt;

  assign s1_go        = s1_valid_r && (!out_valid_r || out_rsp.ready);
  assign s1_client    = (s1_op_r == psda_pkg::OP_CLIENT);
  assign in_req.ready = !s1_valid_r || s1_go;
  assign in_fire      = in_req.valid && in_req.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      s1_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r     <= psda_pkg::op_t'(in_req.operation);
      s1_ip_r     <= in_req.src_ip;
      s1_port_r   <= in_req.src_port;
      s1_seq_r    <= in_req.seq_num;
      s1_val_r    <= in_req.value;
      s1_rcount_r <= in_req.replica_count;
      s1_rsum_r   <= in_req.replica_sum;
    end
  end

  assign tbl_req.en   = s1_go && s1_client;
  assign tbl_req.ip   = s1_ip_r;
  assign tbl_req.port = s1_port_r;
  assign tbl_req.seq  = s1_seq_r;

  psda_table #(
    .CLIENTS(CLIENTS)
  ) u_table (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (tbl_req),
    .res  (tbl_res)
  );

  assign acc_cmd.add        = s1_go && s1_client && !tbl_res.dup;
  assign acc_cmd.load       = s1_go && !s1_client;
  assign acc_cmd.value      = s1_val_r;
  assign acc_cmd.load_count = s1_rcount_r;
  assign acc_cmd.load_sum   = s1_rsum_r;

  psda_acc u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (acc_cmd),
    .total_nxt(total_nxt),
    .count_nxt(count_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_client) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_client) begin
      out_total_r <= total_nxt;
      out_count_r <= count_nxt;
      out_dup_r   <= tbl_res.dup;
      out_untr_r  <= tbl_res.untracked && !tbl_res.dup;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.ack_total    = out_total_r;
  assign out_rsp.ack_count    = out_count_r;
  assign out_rsp.is_duplicate = out_dup_r;
  assign out_rsp.not_tracked  = out_untr_r;

endmodule
`default_nettype wire

FILE: bench/per_source_request_dedup_accumulator_tb.sv
`timescale 1ns / 1ps
module per_source_request_dedup_accumulator_tb;

  localparam int unsigned CLIENTS = psda_pkg::CLIENTS_DEF;
  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 225;
  localparam logic signed [psda_pkg::DATA_W-1:0] SEQ_MIN =
    {1'b1, {(psda_pkg::DATA_W-1){1'b0}}};
  localparam logic signed [psda_pkg::DATA_W-1:0] SEQ_MAX =
    {1'b0, {(psda_pkg::DATA_W-1){1'b1}}};

  typedef struct packed {
    psda_pkg::op_t                      operation;
    logic [psda_pkg::IP_W-1:0]          src_ip;
    logic [psda_pkg::PORT_W-1:0]        src_port;
    logic signed [psda_pkg::DATA_W-1:0] seq_num;
    logic signed [psda_pkg::DATA_W-1:0] value;
    logic [psda_pkg::DATA_W-1:0]        replica_count;
    logic signed [psda_pkg::DATA_W-1:0] replica_sum;
  } request_t;

  typedef struct packed {
    logic signed [psda_pkg::DATA_W-1:0] ack_total;
    logic [psda_pkg::DATA_W-1:0]        ack_count;
    logic                               is_duplicate;
    logic                               not_tracked;
  } ack_t;

  class dedup_scoreboard;
    bit                                 src_known [CLIENTS];
    logic [psda_pkg::IP_W-1:0]          src_ip [CLIENTS];
    logic [psda_pkg::PORT_W-1:0]        src_port [CLIENTS];
    logic signed [psda_pkg::DATA_W-1:0] src_last_seq [CLIENTS];
    logic signed [psda_pkg::DATA_W-1:0] total;
    logic [psda_pkg::DATA_W-1:0]        count;
    ack_t                               acks_due [$];
    int                                 errors;

    function new();
      foreach (src_known[i]) begin
        src_known[i] = 1'b0;
        src_last_seq[i] = '1;
      end
      total = '0;
      count = '0;
      errors = 0;
    endfunction

    function void note_request(request_t r);
      int   hit;
      int   free_slot;
      ack_t want;
      hit = -1;
      free_slot = -1;
      want = '0;
      if (r.operation == psda_pkg::OP_REPLICA) begin
        count = r.replica_count;
        total = r.replica_sum;
        return;
      end
      for (int i = 0; i < CLIENTS; i++) begin
        if (hit < 0 && src_known[i] && src_ip[i] == r.src_ip && src_port[i] == r.src_port)
          hit = i;
        if (free_slot < 0 && !src_known[i])
          free_slot = i;
      end
      if (hit >= 0) begin
        if (r.seq_num <= src_last_seq[hit])
          want.is_duplicate = 1'b1;
        else
          src_last_seq[hit] = r.seq_num;
      end else if (free_slot >= 0) begin
        src_known[free_slot] = 1'b1;
        src_ip[free_slot] = r.src_ip;
        src_port[free_slot] = r.src_port;
        src_last_seq[free_slot] = r.seq_num;
      end else begin
        want.not_tracked = 1'b1;
      end
      if (!want.is_duplicate) begin
        total = total + r.value;
        count = count + 1'b1;
      end
      want.ack_total = total;
      want.ack_count = count;
      acks_due.push_back(want);
    endfunction

    function void mismatch(string field, longint want, longint got);
      errors++;
      if (errors <= 100)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_result(ack_t got);
      ack_t want;
      if (acks_due.size() == 0) begin
        errors++;
        if (errors <= 100)
          $display("%0t: unexpected result: total %0d count %0d dup %0b untracked %0b",
                   $time, got.ack_total, got.ack_count, got.is_duplicate, got.not_tracked);
        return;
      end
      want = acks_due.pop_front();
      if (got.ack_total !== want.ack_total)
        mismatch("ack_total", want.ack_total, got.ack_total);
      if (got.ack_count !== want.ack_count)
        mismatch("ack_count", want.ack_count, got.ack_count);
      if (got.is_duplicate !== want.is_duplicate)
        mismatch("is_duplicate", want.is_duplicate, got.is_duplicate);
      if (got.not_tracked !== want.not_tracked)
        mismatch("not_tracked", want.not_tracked, got.not_tracked);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  psda_in_if  in_req ();
  psda_out_if out_rsp ();

  per_source_request_dedup_accumulator u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  dedup_scoreboard sb = new();

  int req_idle_pct;
  int ack_idle_pct;
  int hold_asked;
  int hold_seen;
  int hold_left;
  int quiet_cycles;

  // known sources; the last entry is the one that never fits in the table
  logic [psda_pkg::IP_W-1:0]          pool_ip [CLIENTS+1];
  logic [psda_pkg::PORT_W-1:0]        pool_port [CLIENTS+1];
  logic signed [psda_pkg::DATA_W-1:0] pool_seq [CLIENTS+1];

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (hold_asked != hold_seen) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_rsp.ready <= 1'b0;
    end else begin
      out_rsp.ready <= ($urandom_range(0, 99) >= ack_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    request_t r;
    ack_t     a;
    if (rst_n) begin
      if (out_rsp.valid && out_rsp.ready) begin
        a.ack_total = out_rsp.ack_total;
        a.ack_count = out_rsp.ack_count;
        a.is_duplicate = out_rsp.is_duplicate;
        a.not_tracked = out_rsp.not_tracked;
        sb.check_result(a);
      end
      if (in_req.valid && in_req.ready) begin
        r.operation = psda_pkg::op_t'(in_req.operation);
        r.src_ip = in_req.src_ip;
        r.src_port = in_req.src_port;
        r.seq_num = in_req.seq_num;
        r.value = in_req.value;
        r.replica_count = in_req.replica_count;
        r.replica_sum = in_req.replica_sum;
        sb.note_request(r);
      end
      if ((out_rsp.valid && out_rsp.ready) || (in_req.valid && in_req.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[per_source_request_dedup_accumulator] ERROR");
        $finish;
      end
    end
  end

  function automatic logic signed [psda_pkg::DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return SEQ_MAX;
      1: return SEQ_MIN;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_req(input request_t r);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.operation <= r.operation;
    in_req.src_ip <= r.src_ip;
    in_req.src_port <= r.src_port;
    in_req.seq_num <= r.seq_num;
    in_req.value <= r.value;
    in_req.replica_count <= r.replica_count;
    in_req.replica_sum <= r.replica_sum;
    do @(posedge clk); while (!in_req.ready);
  endtask

  task automatic send_client(input int k, input logic signed [psda_pkg::DATA_W-1:0] seq,
                             input logic signed [psda_pkg::DATA_W-1:0] val);
    request_t r;
    r.operation = psda_pkg::OP_CLIENT;
    r.src_ip = pool_ip[k];
    r.src_port = pool_port[k];
    r.seq_num = seq;
    r.value = val;
    r.replica_count = $urandom;
    r.replica_sum = $urandom;
    if (seq > pool_seq[k])
      pool_seq[k] = seq;
    send_req(r);
  endtask

  task automatic send_replica(input logic [psda_pkg::DATA_W-1:0] cnt,
                              input logic signed [psda_pkg::DATA_W-1:0] sum);
    request_t r;
    r.operation = psda_pkg::OP_REPLICA;
    r.src_ip = $urandom;
    r.src_port = $urandom;
    r.seq_num = rand_word();
    r.value = rand_word();
    r.replica_count = cnt;
    r.replica_sum = sum;
    send_req(r);
  endtask

  task automatic random_request();
    request_t r;
    int       k;
    int       pick;
    longint   nxt;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_replica(rand_word(), rand_word());
    end else if (pick < 13) begin
      r.operation = psda_pkg::OP_CLIENT;
      r.src_ip = $urandom;
      r.src_port = $urandom;
      r.seq_num = rand_word();
      r.value = rand_word();
      r.replica_count = $urandom;
      r.replica_sum = $urandom;
      send_req(r);
    end else begin
      k = $urandom_range(0, CLIENTS - 1);
      pick = $urandom_range(0, 99);
      nxt = longint'(pool_seq[k]) + longint'($urandom_range(1, 4));
      if (pick < 70 && nxt <= longint'(SEQ_MAX))
        send_client(k, nxt[psda_pkg::DATA_W-1:0], rand_word());
      else if (pick < 88)
        send_client(k, pool_seq[k] - $urandom_range(0, 3), rand_word());
      else
        send_client(k, rand_word(), rand_word());
    end
  endtask

  task automatic wait_for_acks();
    in_req.valid <= 1'b0;
    do @(posedge clk); while (sb.acks_due.size() != 0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_req.valid = 1'b0;
    in_req.operation = psda_pkg::OP_CLIENT;
    in_req.src_ip = '0;
    in_req.src_port = '0;
    in_req.seq_num = '0;
    in_req.value = '0;
    in_req.replica_count = '0;
    in_req.replica_sum = '0;
    out_rsp.ready = 1'b0;
    hold_asked = 0;
    hold_seen = 0;
    hold_left = 0;
    quiet_cycles = 0;
    req_idle_pct = 31;
    ack_idle_pct = 55;

    pool_ip[0] = '0;  pool_port[0] = '0;
    pool_ip[1] = '1;  pool_port[1] = '1;
    pool_ip[2] = '0;  pool_port[2] = '1;
    pool_ip[3] = '1;  pool_port[3] = '0;
    for (int k = 4; k <= CLIENTS; k++) begin
      pool_ip[k] = {8'(k), 24'($urandom)};
      pool_port[k] = $urandom;
    end
    foreach (pool_seq[k])
      pool_seq[k] = SEQ_MIN;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // first request of a source at the lowest sequence, then equal and next
    send_client(0, SEQ_MIN, SEQ_MAX);
    send_client(0, SEQ_MIN, 32'sd5);
    send_client(0, SEQ_MIN + 1, 32'sd1);
    send_client(1, SEQ_MAX, SEQ_MIN);
    send_client(1, '0, 32'sd3);
    send_client(1, SEQ_MAX, 32'sd3);
    // same address or same port as a known source is a new source
    send_client(2, '1, '1);
    send_client(3, 32'sd5, 32'sd100);
    send_client(0, -32'sd5, 32'sd7);
    // overwrite to the wrap point, then a request wraps the count
    send_replica('1, SEQ_MAX);
    send_client(0, -32'sd4, 32'sd1);
    send_replica('0, SEQ_MIN);
    send_client(3, 32'sd5, 32'sd9);
    for (int k = 4; k < CLIENTS; k++)
      send_client(k, rand_word(), rand_word());
    // table full
    send_client(CLIENTS, rand_word(), rand_word());
    send_client(CLIENTS, SEQ_MIN, rand_word());
    send_client(CLIENTS - 1, pool_seq[CLIENTS - 1], rand_word());

    repeat (PHASE_ITEMS) random_request();
    wait_for_acks();

    req_idle_pct = 55;
    ack_idle_pct = 31;
    repeat (PHASE_ITEMS) random_request();
    wait_for_acks();

    req_idle_pct = 0;
    ack_idle_pct = 0;
    hold_asked <= hold_asked + 1;
    repeat (PHASE_ITEMS) random_request();
    wait_for_acks();

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.acks_due.size() == 0)
      $display("[per_source_request_dedup_accumulator] OK");
    else
      $display("[per_source_request_dedup_accumulator] ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
sv/psda_pkg.sv
sv/psda_if.sv
sv/psda_table.sv
sv/psda_acc.sv
sv/per_source_request_dedup_accumulator.sv
bench/per_source_request_dedup_accumulator_tb.sv
